@@ hw/rtl/rpp_pkg.sv @@
`default_nettype none

package rpp_pkg;

    localparam int TS_SEC_W   = 32;
    localparam int TS_USEC_W  = 20;
    localparam int LEN_W      = 18;
    localparam int TAG_W      = 16;
    localparam int BYTES_W    = 32;
    localparam int TIME_W     = 52;
    localparam int SPEED_W    = 20;
    localparam int RATE_W     = 38;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;
    localparam int STEP_W     = 27;

    localparam logic [TIME_W-1:0]  USEC_PER_SEC = TIME_W'(1000000);
    localparam logic [STEP_W-1:0]  TICK_SCALE   = STEP_W'(100);
    localparam logic [SPEED_W-1:0] SPEED_RESET  = SPEED_W'(1000);
    localparam logic [RATE_W-1:0]  RATE_RESET   = '1;

    localparam int RES_DEPTH_DEFAULT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_PKT     = 2'd0,
        MODE_TICK100 = 2'd1,
        MODE_TICK1S  = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_RELEASE = 2'd0,
        KIND_REPORT  = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef struct packed {
        mode_t              mode;
        logic [TIME_W-1:0]  arrival;
        logic [LEN_W-1:0]   len;
        logic [TAG_W-1:0]   tag;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [LEN_W-1:0]   len;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  lag;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

@@ hw/rtl/rpp_evt_if.sv @@
`default_nettype none

interface rpp_evt_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic [rpp_pkg::TS_SEC_W-1:0]  ts_sec;
    logic [rpp_pkg::TS_USEC_W-1:0] ts_usec;
    logic [rpp_pkg::LEN_W-1:0]     packet_len;
    logic [rpp_pkg::TAG_W-1:0]     packet_tag;

    modport source (output valid, mode, ts_sec, ts_usec, packet_len, packet_tag,
                    input ready);
    modport sink   (input valid, mode, ts_sec, ts_usec, packet_len, packet_tag,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rpp_res_if.sv @@
`default_nettype none

interface rpp_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [rpp_pkg::LEN_W-1:0]   out_len;
    logic [rpp_pkg::TAG_W-1:0]   out_tag;
    logic [rpp_pkg::BYTES_W-1:0] report_bytes;
    logic [rpp_pkg::TIME_W-1:0]  report_arrival_us;
    logic [rpp_pkg::TIME_W-1:0]  report_lag_us;
    logic                        last_of_run;

    modport source (output valid, kind, out_len, out_tag, report_bytes,
                    report_arrival_us, report_lag_us, last_of_run, input ready);
    modport sink   (input valid, kind, out_len, out_tag, report_bytes,
                    report_arrival_us, report_lag_us, last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/packet_replay_pacer_top.sv @@
// Channel  Dir  Role
// evt      in   packet, 100 ms tick, 1 s tick or restart word
// res      out  release, report, discard or busy-reject word
// cfg_*    in   register writes, no handshake
//
// One evt word per cycle while each word gives at most one result.
// From accept to res, a word passes the input register, the arrival
// multiply register, then the state update into the result queue.
// A 1 s tick that releases a held word pushes two results; the pipe
// holds while the queue has over RES_DEPTH-2 words, or on res stalls.
// Reset clears all pacing state; no clearing pass.
`default_nettype none

module packet_replay_pacer_top #(
    parameter int RES_DEPTH = rpp_pkg::RES_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0] cfg_data,
    rpp_evt_if.sink                             evt,
    rpp_res_if.source                           res
);
    import rpp_pkg::*;

    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_mode_reg;
    logic [TS_SEC_W-1:0]  s1_sec_reg;
    logic [TS_USEC_W-1:0] s1_usec_reg;
    logic [LEN_W-1:0]     s1_len_reg;
    logic [TAG_W-1:0]     s1_tag_reg;
    logic                 s2_valid_reg, s2_valid_next;
    item_t                s2_item_reg;
    item_t                s2_item_next;

    logic    accept, s1_move, s1_free, s2_fire, s2_free, room2;
    push_t   push;
    result_t head;

    always_comb
    begin
        s2_fire   = s2_valid_reg && room2;
        s2_free   = !s2_valid_reg || s2_fire;
        s1_move   = s1_valid_reg && s2_free;
        s1_free   = !s1_valid_reg || s1_move;
        evt.ready = s1_free;
        accept    = evt.valid && s1_free;

        s1_valid_next = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_move ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);

        s2_item_next.mode    = mode_t'(s1_mode_reg);
        s2_item_next.arrival = ({(TIME_W-TS_SEC_W)'(0), s1_sec_reg} * USEC_PER_SEC)
                               + TIME_W'(s1_usec_reg);
        s2_item_next.len     = s1_len_reg;
        s2_item_next.tag     = s1_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= evt.mode;
            s1_sec_reg  <= evt.ts_sec;
            s1_usec_reg <= evt.ts_usec;
            s1_len_reg  <= evt.packet_len;
            s1_tag_reg  <= evt.packet_tag;
        end
        if (s1_move)
            s2_item_reg <= s2_item_next;
    end

    rpp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .fire     (s2_fire),
        .item     (s2_item_reg),
        .push     (push)
    );

    rpp_resq #(
        .DEPTH (RES_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room2 (room2),
        .valid (res.valid),
        .ready (res.ready),
        .head  (head)
    );

    assign res.kind              = head.kind;
    assign res.out_len           = head.len;
    assign res.out_tag           = head.tag;
    assign res.report_bytes      = head.bytes;
    assign res.report_arrival_us = head.arrival;
    assign res.report_lag_us     = head.lag;
    assign res.last_of_run       = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/rpp_core.sv @@
`default_nettype none

module rpp_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              fire,
    input  wire rpp_pkg::item_t                    item,
    output rpp_pkg::push_t                         push
);
    import rpp_pkg::*;

    logic [SPEED_W-1:0] speed_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic [TIME_W-1:0]  clk_reg, clk_next;
    logic [TIME_W-1:0]  last_reg, last_next;
    logic [TIME_W-1:0]  lag_reg, lag_next;
    logic [BYTES_W-1:0] sent_reg, sent_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_load;
    logic [TIME_W-1:0]  pend_arr_reg;
    logic [LEN_W-1:0]   pend_len_reg;
    logic [TAG_W-1:0]   pend_tag_reg;

    logic               rate_neg, rate_pos;
    logic [STEP_W-1:0]  step;
    logic [TIME_W:0]    clk_sum;
    logic [TIME_W-1:0]  clk_adv;
    logic [TIME_W-1:0]  t_arr, t_clk, seed_clk, t_clk_next, t_lag_next;
    logic [BYTES_W-1:0] t_sent, sent_rel;
    logic [LEN_W-1:0]   rel_len;
    logic [TAG_W-1:0]   rel_tag;
    logic [BYTES_W:0]   rel_sum;
    logic               tl_go, rt_go, go;
    result_t            rel_res;
    push_t              push_c;

    function automatic result_t make_res(kind_t k, logic [LEN_W-1:0] len,
                                         logic [TAG_W-1:0] tag,
                                         logic [BYTES_W-1:0] bytes,
                                         logic [TIME_W-1:0] arr,
                                         logic [TIME_W-1:0] lag);
        result_t r;
        r.kind    = k;
        r.len     = len;
        r.tag     = tag;
        r.bytes   = bytes;
        r.arrival = arr;
        r.lag     = lag;
        r.last    = 1'b0;
        return r;
    endfunction

    // shared pacing test: new packet, or the held one on a tick
    always_comb
    begin
        rate_neg = rate_reg[RATE_W-1];
        rate_pos = !rate_neg && (rate_reg != '0);
        step     = STEP_W'(speed_reg) * TICK_SCALE;
        clk_sum  = {1'b0, clk_reg} + (TIME_W+1)'(step);
        if (clk_reg == '0)
            clk_adv = clk_reg;
        else if (clk_sum[TIME_W])
            clk_adv = '1;
        else
            clk_adv = clk_sum[TIME_W-1:0];

        t_arr   = (item.mode == MODE_PKT) ? item.arrival : pend_arr_reg;
        rel_len = (item.mode == MODE_PKT) ? item.len : pend_len_reg;
        rel_tag = (item.mode == MODE_PKT) ? item.tag : pend_tag_reg;
        t_clk   = (item.mode == MODE_TICK100) ? clk_adv : clk_reg;
        t_sent  = (item.mode == MODE_TICK1S) ? '0 : sent_reg;

        seed_clk   = (t_clk == '0) ? t_arr : t_clk;
        tl_go      = !(t_arr > seed_clk);
        rt_go      = !(rate_pos && ({2'b00, t_sent, 3'b000} > rate_reg[RATE_W-2:0]));
        go         = rate_neg ? tl_go : rt_go;
        t_clk_next = rate_neg ? seed_clk : t_clk;
        t_lag_next = (rate_neg && !tl_go) ? (t_arr - seed_clk) : lag_reg;

        rel_sum  = {1'b0, t_sent} + (BYTES_W+1)'(rel_len);
        sent_rel = rel_sum[BYTES_W] ? '1 : rel_sum[BYTES_W-1:0];
        rel_res  = make_res(KIND_RELEASE, rel_len, rel_tag, '0, '0, '0);
    end

    always_comb
    begin
        clk_next        = clk_reg;
        last_next       = last_reg;
        lag_next        = lag_reg;
        sent_next       = sent_reg;
        pend_valid_next = pend_valid_reg;
        pend_load       = 1'b0;
        push_c.n        = 2'd0;
        push_c.r0       = rel_res;
        push_c.r1       = rel_res;
        if (fire)
        begin
            case (item.mode)
                MODE_PKT:
                begin
                    if (pend_valid_reg)
                    begin
                        push_c.r0 = make_res(KIND_REJECT, item.len, item.tag, '0, '0, '0);
                        push_c.n  = 2'd1;
                    end
                    else
                    begin
                        clk_next = t_clk_next;
                        lag_next = t_lag_next;
                        if (go)
                        begin
                            last_next = t_arr;
                            sent_next = sent_rel;
                            push_c.n  = 2'd1;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_load       = 1'b1;
                        end
                    end
                end
                MODE_TICK100:
                begin
                    clk_next = clk_adv;
                    if (pend_valid_reg)
                    begin
                        clk_next = t_clk_next;
                        lag_next = t_lag_next;
                        if (go)
                        begin
                            pend_valid_next = 1'b0;
                            last_next       = t_arr;
                            sent_next       = sent_rel;
                            push_c.n        = 2'd1;
                        end
                    end
                end
                MODE_TICK1S:
                begin
                    push_c.r0 = make_res(KIND_REPORT, '0, '0, sent_reg, last_reg, lag_reg);
                    push_c.n  = 2'd1;
                    sent_next = '0;
                    if (pend_valid_reg)
                    begin
                        clk_next = t_clk_next;
                        lag_next = t_lag_next;
                        if (go)
                        begin
                            pend_valid_next = 1'b0;
                            last_next       = t_arr;
                            sent_next       = sent_rel;
                            push_c.n        = 2'd2;
                        end
                    end
                end
                MODE_RESTART:
                begin
                    clk_next  = '0;
                    last_next = '0;
                    lag_next  = '0;
                    if (pend_valid_reg)
                    begin
                        pend_valid_next = 1'b0;
                        push_c.r0 = make_res(KIND_DISCARD, pend_len_reg, pend_tag_reg,
                                             '0, '0, '0);
                        push_c.n  = 2'd1;
                    end
                end
                default:
                begin
                    push_c.n = 2'd0;
                end
            endcase
        end
        push_c.r0.last = (push_c.n == 2'd1);
        push_c.r1.last = 1'b1;
    end

    assign push = push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg      <= SPEED_RESET;
            rate_reg       <= RATE_RESET;
            clk_reg        <= '0;
            last_reg       <= '0;
            lag_reg        <= '0;
            sent_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_SPEED: speed_reg <= cfg_data[SPEED_W-1:0];
                    REG_RATE:  rate_reg  <= cfg_data[RATE_W-1:0];
                    default:   rate_reg  <= rate_reg;
                endcase
            end
            clk_reg        <= clk_next;
            last_reg       <= last_next;
            lag_reg        <= lag_next;
            sent_reg       <= sent_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_arr_reg <= item.arrival;
            pend_len_reg <= item.len;
            pend_tag_reg <= item.tag;
        end
    end

    a_restart_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_RESTART) |=> (!pend_valid_reg && clk_reg == '0))
        else $error("restart left a held word or a seeded clock");

    a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && item.mode == MODE_RESTART) |=> (clk_reg >= $past(clk_reg)))
        else $error("virtual clock moved backward");

    a_bytes_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && item.mode == MODE_TICK1S) |=> (sent_reg >= $past(sent_reg)))
        else $error("byte count dropped outside a report");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_PKT && pend_valid_reg)
        |=> (pend_valid_reg && $stable(pend_arr_reg)))
        else $error("busy reject disturbed the held word");

endmodule

`default_nettype wire

@@ hw/rtl/rpp_resq.sv @@
`default_nettype none

module rpp_resq #(
    parameter int DEPTH = rpp_pkg::RES_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rpp_pkg::push_t push,
    output logic                room2,
    output logic                valid,
    input  wire logic           ready,
    output rpp_pkg::result_t    head
);
    import rpp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next, wr_plus1;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;

    function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        valid    = (cnt_reg != '0);
        room2    = (cnt_reg <= CW'(DEPTH - 2));
        pop      = valid && ready;
        head     = mem[rd_reg];
        wr_plus1 = inc(wr_reg);
        case (push.n)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = inc(wr_plus1);
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_reg] <= push.r0;
        if (push.n == 2'd2)
            mem[wr_plus1] <= push.r1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> (cnt_reg <= CW'(DEPTH - 2)))
        else $error("result queue written without room");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CW'(DEPTH)) && (push.n != 2'd3))
        else $error("result queue count out of range");

endmodule

`default_nettype wire
